// File: rtl/radix2_stockham_fft_unit_defines.svh
// Assertion macros for the FFT unit checker.
`ifndef RADIX2_STOCKHAM_FFT_UNIT_DEFINES_SVH
`define RADIX2_STOCKHAM_FFT_UNIT_DEFINES_SVH
// Assert an implication under active-low synchronous reset.
`define R2F_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Assert a next-cycle implication under active-low synchronous reset.
`define R2F_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/r2fft_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_pkg
// Shared types and constants for the Stockham FFT unit.
// ----------------------------------------------------------------------------
package r2fft_pkg;
    localparam int MAX_POINTS_DEF = 1024;
    localparam int DATA_WIDTH_DEF = 28;
    localparam int IN_WIDTH = 16;
    localparam int TW_WIDTH = 16;
    localparam int KIND_WIDTH = 2;
    localparam int INDEX_WIDTH = 10;
    localparam int LOG2_WIDTH = 4;
    localparam int CFG_IDX_WIDTH = 1;
    localparam int CFG_DATA_WIDTH = 4;

    typedef logic [KIND_WIDTH-1:0] t_kind;
    localparam t_kind KIND_LOAD_SAMPLE = 2'd0;
    localparam t_kind KIND_LOAD_TWIDDLE = 2'd1;
    localparam t_kind KIND_RUN = 2'd2;
    localparam t_kind KIND_READ = 2'd3;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_LOG2_POINTS = 1'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_INVERSE = 1'd1;

    // Commands from controller to datapath.
    typedef struct packed {
        logic load_sample;   // write sample into first buffer
        logic load_twiddle;  // write twiddle store
        logic read_req;      // issue read of result buffer
        logic bfly_issue;    // issue butterfly reads for current address
        logic stage_start;   // begin a stage (flip direction)
        logic run_start;     // begin a run
        logic run_done;      // run finished, latch result location
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic wr_busy;       // butterfly pipeline still writing back
    } t_status;
endpackage

// File: rtl/r2fft_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_ram
// Generic single-write, dual-read RAM with registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// File: rtl/r2fft_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_datapath
// Buffers, twiddle store, butterfly pipeline and output register.
// ----------------------------------------------------------------------------
module r2fft_datapath #(
    parameter int MAX_POINTS = r2fft_pkg::MAX_POINTS_DEF,
    parameter int DATA_WIDTH = r2fft_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  r2fft_pkg::t_cmd                     i_cmd,
    output r2fft_pkg::t_status                  o_status,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_idx,
    input  logic                                i_idx_ok,
    input  logic signed [r2fft_pkg::IN_WIDTH-1:0] i_vr,
    input  logic signed [r2fft_pkg::IN_WIDTH-1:0] i_vi,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_half,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_span,
    input  logic [$clog2(MAX_POINTS)-1:0]       i_addr,
    input  logic                                i_inverse,
    output logic signed [DATA_WIDTH-1:0]        o_re,
    output logic signed [DATA_WIDTH-1:0]        o_im,
    output logic                                o_rd_valid
);
    import r2fft_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int TD = MAX_POINTS / 2;
    localparam int TAW = $clog2(TD);
    localparam int WW = 2 * DATA_WIDTH;
    localparam int PW = DATA_WIDTH + TW_WIDTH + 1;
    localparam logic signed [DATA_WIDTH-1:0] DMAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DMIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    function automatic logic signed [DATA_WIDTH-1:0] sat_d(
        input logic signed [DATA_WIDTH:0] v);
        if (v > $signed({{1{1'b0}}, DMAX})) return DMAX;
        if (v < $signed({1'b1, DMIN})) return DMIN;
        return v[DATA_WIDTH-1:0];
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] sat_p(
        input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = PW'(DMAX);
        lo = PW'(DMIN);
        if (v > hi) return DMAX;
        if (v < lo) return DMIN;
        return v[DATA_WIDTH-1:0];
    endfunction

    // Result location and ping-pong direction.
    logic r_res_second;
    logic r_src_second;

    // Butterfly pipeline control.
    logic          r_v1, r_v2, r_v3;
    logic [AW-1:0] r_c1, r_c2, r_c3;
    logic [AW-1:0] r_sp1, r_sp2, r_sp3;
    logic          r_dst1, r_dst2, r_dst3;
    logic          r_rdv;

    // Address split: addr = j*span + k, span power of two.
    logic [AW-1:0] w_k, w_jm, w_ia, w_ib, w_ic;
    assign w_k  = i_addr & (i_span - AW'(1));
    assign w_jm = i_addr & ~(i_span - AW'(1));
    assign w_ia = i_addr;
    assign w_ib = i_addr + i_half;
    assign w_ic = AW'({w_jm, 1'b0}) + w_k;

    logic [WW-1:0] w_f_rda, w_f_rdb, w_s_rda, w_s_rdb;
    logic [AW-1:0] w_ra, w_rb;
    logic          w_f_we, w_s_we;
    logic [AW-1:0] w_f_wa, w_s_wa;
    logic [WW-1:0] w_f_wd, w_s_wd;
    logic [2*TW_WIDTH-1:0] w_tw_a, w_tw_b;
    logic [WW-1:0] w_rd;

    assign w_ra = i_cmd.read_req ? i_idx : w_ia;
    assign w_rb = w_ib;
    assign w_rd = r_res_second ? w_s_rda : w_f_rda;

    // Stage 2: sum and difference.
    logic signed [DATA_WIDTH-1:0] r_cr, r_ci, r_dr, r_di;
    logic signed [TW_WIDTH-1:0]   r_wr;
    logic signed [TW_WIDTH:0]     r_wi;
    // Stage 3: products.
    logic signed [PW-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [DATA_WIDTH-1:0] r_cr3, r_ci3;
    // Write-back of c at stage 3, d at stage 4.
    logic signed [DATA_WIDTH-1:0] r_dro, r_dio;
    logic [AW-1:0] r_id4;
    logic          r_dst4, r_v4;

    logic [WW-1:0] w_a, w_b;
    assign w_a = r_src_second ? w_s_rda : w_f_rda;
    assign w_b = r_src_second ? w_s_rdb : w_f_rdb;

    logic signed [DATA_WIDTH-1:0] w_ar, w_ai, w_br, w_bi;
    assign w_ar = w_a[WW-1:DATA_WIDTH];
    assign w_ai = w_a[DATA_WIDTH-1:0];
    assign w_br = w_b[WW-1:DATA_WIDTH];
    assign w_bi = w_b[DATA_WIDTH-1:0];

    // Conjugation needs one extra bit: the negated full-scale sine is +1.0.
    logic signed [TW_WIDTH-1:0] w_twr, w_twi_raw;
    logic signed [TW_WIDTH:0]   w_twi;
    assign w_twr = w_tw_a[2*TW_WIDTH-1:TW_WIDTH];
    assign w_twi_raw = w_tw_b[TW_WIDTH-1:0];
    assign w_twi = i_inverse ? -(TW_WIDTH+1)'(w_twi_raw) : (TW_WIDTH+1)'(w_twi_raw);

    logic signed [PW:0] w_sr, w_si;
    assign w_sr = (PW+1)'(r_p1) - (PW+1)'(r_p2);
    assign w_si = (PW+1)'(r_p3) + (PW+1)'(r_p4);
    logic signed [PW:0] w_shr, w_shi;
    assign w_shr = w_sr >>> 15;
    assign w_shi = w_si >>> 15;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_second <= 1'b0;
            r_src_second <= 1'b0;
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0;
            r_rdv <= 1'b0;
            o_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.run_start) begin
                r_src_second <= 1'b0;
            end else if (i_cmd.stage_start) begin
                r_src_second <= ~r_src_second;
            end
            // The last stage wrote the buffer opposite its source.
            if (i_cmd.run_done) begin
                r_res_second <= ~r_src_second;
            end
            r_v1 <= i_cmd.bfly_issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_rdv <= i_cmd.read_req;
            o_rd_valid <= r_rdv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1 <= w_ic; r_sp1 <= i_span; r_dst1 <= ~r_src_second;
        r_c2 <= r_c1; r_sp2 <= r_sp1; r_dst2 <= r_dst1;
        r_c3 <= r_c2; r_sp3 <= r_sp2; r_dst3 <= r_dst2;
        r_cr <= sat_d((DATA_WIDTH+1)'(w_ar) + (DATA_WIDTH+1)'(w_br));
        r_ci <= sat_d((DATA_WIDTH+1)'(w_ai) + (DATA_WIDTH+1)'(w_bi));
        r_dr <= sat_d((DATA_WIDTH+1)'(w_ar) - (DATA_WIDTH+1)'(w_br));
        r_di <= sat_d((DATA_WIDTH+1)'(w_ai) - (DATA_WIDTH+1)'(w_bi));
        r_wr <= w_twr;
        r_wi <= w_twi;
        r_p1 <= PW'(r_wr * r_dr);
        r_p2 <= PW'(r_wi * r_di);
        r_p3 <= PW'(r_wi * r_dr);
        r_p4 <= PW'(r_wr * r_di);
        r_cr3 <= r_cr; r_ci3 <= r_ci;
        r_dro <= sat_p(w_shr[PW-1:0]);
        r_dio <= sat_p(w_shi[PW-1:0]);
        r_id4 <= r_c3 + r_sp3;
        r_dst4 <= r_dst3;
        if (r_rdv) begin
            o_re <= w_rd[WW-1:DATA_WIDTH];
            o_im <= w_rd[DATA_WIDTH-1:0];
        end
    end

    // Write port arbitration: c at stage 3 and d at stage 4 share a port per
    // buffer; controller spaces issues apart so they never meet.
    always_comb begin
        w_f_we = 1'b0; w_s_we = 1'b0;
        w_f_wa = r_c3; w_s_wa = r_c3;
        w_f_wd = {r_cr3, r_ci3}; w_s_wd = {r_cr3, r_ci3};
        if (i_cmd.load_sample) begin
            w_f_we = 1'b1;
            w_f_wa = i_idx;
            w_f_wd = {DATA_WIDTH'(i_vr), DATA_WIDTH'(i_vi)};
        end else if (r_v3) begin
            w_f_we = ~r_dst3;
            w_s_we = r_dst3;
        end else if (r_v4) begin
            w_f_we = ~r_dst4;
            w_s_we = r_dst4;
            w_f_wa = r_id4; w_s_wa = r_id4;
            w_f_wd = {r_dro, r_dio}; w_s_wd = {r_dro, r_dio};
        end
    end

    r2fft_ram #(.WIDTH(WW), .DEPTH(MAX_POINTS)) u_first (
        .i_clk(i_clk), .i_we(w_f_we), .i_waddr(w_f_wa), .i_wdata(w_f_wd),
        .i_raddr_a(w_ra), .o_rdata_a(w_f_rda), .i_raddr_b(w_rb), .o_rdata_b(w_f_rdb));
    r2fft_ram #(.WIDTH(WW), .DEPTH(MAX_POINTS)) u_second (
        .i_clk(i_clk), .i_we(w_s_we), .i_waddr(w_s_wa), .i_wdata(w_s_wd),
        .i_raddr_a(w_ra), .o_rdata_a(w_s_rda), .i_raddr_b(w_rb), .o_rdata_b(w_s_rdb));
    // Both ports read the same twiddle: cosine from port a, sine from port b.
    r2fft_ram #(.WIDTH(2*TW_WIDTH), .DEPTH(TD)) u_twiddle (
        .i_clk(i_clk), .i_we(i_cmd.load_twiddle & i_idx_ok),
        .i_waddr(i_idx[TAW-1:0]), .i_wdata({i_vr, i_vi}),
        .i_raddr_a(w_jm[TAW-1:0]), .o_rdata_a(w_tw_a),
        .i_raddr_b(w_jm[TAW-1:0]), .o_rdata_b(w_tw_b));

    assign o_status.wr_busy = r_v1 | r_v2 | r_v3 | r_v4;
endmodule

// File: rtl/r2fft_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// r2fft_ctrl
// Controller: item decode, stage and butterfly sequencing, output handshake.
// ----------------------------------------------------------------------------
module r2fft_ctrl #(
    parameter int MAX_POINTS = r2fft_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  r2fft_pkg::t_kind                     i_kind,
    input  logic [r2fft_pkg::INDEX_WIDTH-1:0]    i_index,
    input  logic [r2fft_pkg::LOG2_WIDTH-1:0]     i_log2,
    input  logic                                 i_rd_valid,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    input  r2fft_pkg::t_status                   i_status,
    output r2fft_pkg::t_cmd                      o_cmd,
    output logic [$clog2(MAX_POINTS)-1:0]        o_idx,
    output logic                                 o_idx_ok,
    output logic [$clog2(MAX_POINTS)-1:0]        o_half,
    output logic [$clog2(MAX_POINTS)-1:0]        o_span,
    output logic [$clog2(MAX_POINTS)-1:0]        o_addr
);
    import r2fft_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int SW = $clog2(AW + 1);
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_GAP  = 2'd2;
    localparam logic [1:0] ST_DRAIN = 2'd3;

    logic [1:0]    r_state, n_state;
    logic [SW-1:0] r_stage, n_stage;
    logic [AW-1:0] r_addr, n_addr;
    logic          r_ph, n_ph;
    logic          r_rd_pend, r_out_valid;
    logic [SW-1:0] w_m;
    logic [AW:0]   w_n;

    // Effective log2 length, clamped to 1..AW.
    always_comb begin
        if (i_log2 == '0) w_m = SW'(1);
        else if (32'(i_log2) > AW) w_m = SW'(AW);
        else w_m = SW'(i_log2);
    end
    assign w_n = (AW+1)'(1) << w_m;

    logic w_acc;
    assign o_ready = (r_state == ST_IDLE) && !r_rd_pend && !r_out_valid;
    assign w_acc = i_valid && o_ready;

    assign o_half = w_n[AW:1];
    assign o_span = AW'(1) << r_stage;
    assign o_addr = r_addr;
    assign o_idx  = (i_kind == KIND_READ) ?
                    AW'(i_index) & (w_n[AW-1:0] - AW'(1)) : AW'(i_index);
    assign o_idx_ok = 32'(i_index) < MAX_POINTS / 2;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_stage = r_stage;
        n_addr = r_addr;
        n_ph = r_ph;
        o_cmd = '0;
        o_cmd.load_sample  = w_acc && i_kind == KIND_LOAD_SAMPLE;
        o_cmd.load_twiddle = w_acc && i_kind == KIND_LOAD_TWIDDLE;
        o_cmd.read_req     = w_acc && i_kind == KIND_READ;
        case (r_state)
            ST_IDLE: begin
                if (w_acc && i_kind == KIND_RUN) begin
                    o_cmd.run_start = 1'b1;
                    n_state = ST_RUN;
                    n_stage = '0;
                    n_addr = '0;
                    n_ph = 1'b0;
                end
            end
            ST_RUN: begin
                // Issue a butterfly only while the phase bit r_ph is clear.
                n_ph = ~r_ph;
                if (!r_ph) begin
                    o_cmd.bfly_issue = 1'b1;
                    if (r_addr == o_half - AW'(1)) begin
                        n_state = ST_GAP;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
            end
            ST_GAP: begin
                // Wait for stage write-back before next stage reads.
                if (!i_status.wr_busy) begin
                    n_addr = '0;
                    n_ph = 1'b0;
                    if (r_stage == w_m - SW'(1)) begin
                        n_state = ST_DRAIN;
                    end else begin
                        o_cmd.stage_start = 1'b1;
                        n_stage = r_stage + SW'(1);
                        n_state = ST_RUN;
                    end
                end
            end
            ST_DRAIN: begin
                o_cmd.stage_start = 1'b1;
                o_cmd.run_done = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_stage <= '0;
            r_addr <= '0;
            r_ph <= 1'b0;
            r_rd_pend <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_addr <= n_addr;
            r_ph <= n_ph;
            if (o_cmd.read_req) r_rd_pend <= 1'b1;
            else if (i_rd_valid) r_rd_pend <= 1'b0;
            if (i_rd_valid) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end
endmodule

// File: rtl/radix2_stockham_fft_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix2_stockham_fft_unit
// Fixed-point radix-2 Stockham autosort FFT with sample/twiddle memories.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake            Payload
// input    in         i_valid / o_ready    i_kind, i_index, i_value_real/imag
// output   out        o_valid / i_ready    o_out_real, o_out_imag
// config   in         i_cfg_we             i_cfg_index, i_cfg_data
//
// Loads do not hold the input. A read passes through the registered memory
// read and the output register, and holds the input until the result is taken.
// A run holds the input until its last stage is written back: butterfly issues
// are spaced so c and d share each buffer's single write port, and each stage
// waits for its last write-back.
// Reset is synchronous, active low; memories hold no reset.
// Output stalls hold the result register and block new input.
module radix2_stockham_fft_unit #(
    parameter int MAX_POINTS = r2fft_pkg::MAX_POINTS_DEF,
    parameter int DATA_WIDTH = r2fft_pkg::DATA_WIDTH_DEF
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [r2fft_pkg::KIND_WIDTH-1:0]         i_kind,
    input  logic [r2fft_pkg::INDEX_WIDTH-1:0]        i_index,
    input  logic signed [r2fft_pkg::IN_WIDTH-1:0]    i_value_real,
    input  logic signed [r2fft_pkg::IN_WIDTH-1:0]    i_value_imag,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [DATA_WIDTH-1:0]             o_out_real,
    output logic signed [DATA_WIDTH-1:0]             o_out_imag,
    input  logic                                     i_cfg_we,
    input  logic [r2fft_pkg::CFG_IDX_WIDTH-1:0]      i_cfg_index,
    input  logic [r2fft_pkg::CFG_DATA_WIDTH-1:0]     i_cfg_data
);
    import r2fft_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    // Configuration registers.
    logic [LOG2_WIDTH-1:0] r_log2;
    logic                  r_inverse;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_log2 <= LOG2_WIDTH'(10);
            r_inverse <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LOG2_POINTS: r_log2 <= i_cfg_data;
                REG_INVERSE:     r_inverse <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    t_cmd          w_cmd;
    t_status       w_status;
    logic [AW-1:0] w_idx, w_half, w_span, w_addr;
    logic          w_idx_ok, w_rd_valid;

    r2fft_ctrl #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_kind(i_kind), .i_index(i_index), .i_log2(r_log2),
        .i_rd_valid(w_rd_valid), .i_out_ready(i_ready), .o_out_valid(o_valid),
        .i_status(w_status), .o_cmd(w_cmd),
        .o_idx(w_idx), .o_idx_ok(w_idx_ok),
        .o_half(w_half), .o_span(w_span), .o_addr(w_addr)
    );

    r2fft_datapath #(.MAX_POINTS(MAX_POINTS), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd(w_cmd), .o_status(w_status),
        .i_idx(w_idx), .i_idx_ok(w_idx_ok),
        .i_vr(i_value_real), .i_vi(i_value_imag),
        .i_half(w_half), .i_span(w_span), .i_addr(w_addr),
        .i_inverse(r_inverse),
        .o_re(o_out_real), .o_im(o_out_imag), .o_rd_valid(w_rd_valid)
    );
endmodule

// File: rtl/r2fft_checker.sv
`timescale 1ns / 1ps
`include "radix2_stockham_fft_unit_defines.svh"
// ----------------------------------------------------------------------------
// r2fft_checker
// Port-level checks on the FFT unit's handshakes.
// ----------------------------------------------------------------------------
module r2fft_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_valid,
    input logic o_ready,
    input r2fft_pkg::t_kind i_kind,
    input logic o_valid,
    input logic i_ready
);
    import r2fft_pkg::*;

    `R2F_ASSERT_IMPL(a_no_ready_with_out, i_clk, i_rst_n, o_valid, !o_ready,
        "input ready while a result waits")
    `R2F_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, o_valid && !i_ready, o_valid,
        "result dropped while stalled")
    `R2F_ASSERT_NEXT(a_run_blocks, i_clk, i_rst_n, i_valid && o_ready && i_kind == KIND_RUN,
        !o_ready, "input ready right after a run was taken")
    `R2F_ASSERT_NEXT(a_load_no_out, i_clk, i_rst_n,
        i_valid && o_ready && i_kind == KIND_LOAD_SAMPLE && !o_valid, !o_valid,
        "result after a sample load")
endmodule

bind radix2_stockham_fft_unit r2fft_checker u_r2fft_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .i_kind(i_kind), .o_valid(o_valid), .i_ready(i_ready)
);

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radix-2 Stockham FFT unit: a directed table,
// then randomized load/run/read sequences checked against a local predictor.
// ----------------------------------------------------------------------------
module tb;
    import r2fft_pkg::*;

    localparam int NPTS = 1024;
    localparam int DW   = 28;

    typedef struct {
        logic signed [DW-1:0] re;
        logic signed [DW-1:0] im;
    } t_point;

    // One row of the directed table; config rows reuse idx as register index
    // and vr as register data.
    typedef struct {
        bit          is_cfg;
        t_kind       kind;
        int          idx;
        int          vr;
        int          vi;
        bit          typed;
        int          er;
        int          ei;
    } t_dir_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_valid;
    logic                       o_ready;
    logic [KIND_WIDTH-1:0]      i_kind;
    logic [INDEX_WIDTH-1:0]     i_index;
    logic signed [IN_WIDTH-1:0] i_value_real;
    logic signed [IN_WIDTH-1:0] i_value_imag;
    logic                       o_valid;
    logic                       i_ready;
    logic signed [DW-1:0]       o_out_real;
    logic signed [DW-1:0]       o_out_imag;
    logic                       i_cfg_we;
    logic [CFG_IDX_WIDTH-1:0]   i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;

    radix2_stockham_fft_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_kind       (i_kind),
        .i_index      (i_index),
        .i_value_real (i_value_real),
        .i_value_imag (i_value_imag),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_real   (o_out_real),
        .o_out_imag   (o_out_imag),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // Predictor state: two data buffers (0 = first, 1 = second), twiddles,
    // written flags so the stimulus never reads an entry that holds nothing.
    longint pd_re [2][NPTS];
    longint pd_im [2][NPTS];
    bit     pd_ok [2][NPTS];
    longint tw_re [NPTS/2];
    longint tw_im [NPTS/2];
    bit     tw_ok [NPTS/2];
    bit     res_in_second;
    int     cfg_log2;
    bit     cfg_inv;

    t_point pending_points[$];

    int send_idle_pct;
    int recv_idle_pct;
    int stall_asks;
    int stall_seen = 0;
    int stall_left = 0;

    int mismatches;
    int orphans;
    int points_checked;
    int items_sent;
    int runs_done;
    int reads_sent;

    // ------------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic longint sat_dw(longint v);
        longint lim;
        lim = longint'(1) <<< (DW - 1);
        if (v > lim - 1) return lim - 1;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Effective transform size: 0 acts as 1, anything past 10 clamps to 10.
    function automatic int eff_log2();
        if (cfg_log2 < 1) return 1;
        if (cfg_log2 > 10) return 10;
        return cfg_log2;
    endfunction

    function automatic void fft_butterfly_stage(int n, int span, int sb);
        int     db;
        longint wr, wi, ar, ai, br, bi, dr, di;
        int     ia, ib, ic, id;
        db = 1 - sb;
        for (int j = 0; j < (n / 2) / span; j++) begin
            wr = tw_re[j * span];
            wi = tw_im[j * span];
            if (cfg_inv) wi = -wi;
            for (int k = 0; k < span; k++) begin
                ia = j * span + k;
                ib = ia + n / 2;
                ic = 2 * j * span + k;
                id = ic + span;
                ar = pd_re[sb][ia];
                ai = pd_im[sb][ia];
                br = pd_re[sb][ib];
                bi = pd_im[sb][ib];
                dr = sat_dw(ar - br);
                di = sat_dw(ai - bi);
                pd_re[db][ic] = sat_dw(ar + br);
                pd_im[db][ic] = sat_dw(ai + bi);
                // arithmetic shift of a signed longint floors, as required
                pd_re[db][id] = sat_dw((wr * dr - wi * di) >>> 15);
                pd_im[db][id] = sat_dw((wi * dr + wr * di) >>> 15);
                pd_ok[db][ic] = 1'b1;
                pd_ok[db][id] = 1'b1;
            end
        end
    endfunction

    function automatic void fft_predict_run();
        int m;
        int sb;
        m  = eff_log2();
        sb = 0;
        for (int s = 0; s < m; s++) begin
            fft_butterfly_stage(1 << m, 1 << s, sb);
            sb = 1 - sb;
        end
        res_in_second = (sb == 1);
    endfunction

    // Apply one accepted transaction; return 1 with the point for a read.
    function automatic bit fft_apply(t_kind kind, int idx, int vr, int vi,
                                     output t_point pt);
        int p;
        pt.re = '0;
        pt.im = '0;
        case (kind)
            KIND_LOAD_SAMPLE: begin
                pd_re[0][idx] = vr;
                pd_im[0][idx] = vi;
                pd_ok[0][idx] = 1'b1;
            end
            KIND_LOAD_TWIDDLE: begin
                if (idx < NPTS / 2) begin
                    tw_re[idx] = vr;
                    tw_im[idx] = vi;
                    tw_ok[idx] = 1'b1;
                end
            end
            KIND_RUN: begin
                fft_predict_run();
                runs_done++;
            end
            default: begin
                p = idx & ((1 << eff_log2()) - 1);
                pt.re = pd_re[res_in_second][p];
                pt.im = pd_im[res_in_second][p];
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic bit read_is_safe(int idx);
        return pd_ok[res_in_second][idx & ((1 << eff_log2()) - 1)];
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // Offer one transaction; valid stays high after acceptance so that a
    // back-to-back item does not drop it within the same step.
    task automatic send_item(t_kind kind, int idx, int vr, int vi,
                             bit typed = 0, int er = 0, int ei = 0);
        t_point pt;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_index      <= idx[INDEX_WIDTH-1:0];
        i_value_real <= vr[IN_WIDTH-1:0];
        i_value_imag <= vi[IN_WIDTH-1:0];
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
        if (fft_apply(kind, idx, vr, vi, pt)) begin
            reads_sent++;
            if (typed) begin
                pt.re = er;
                pt.im = ei;
            end
            pending_points.push_back(pt);
        end
    endtask

    // Drop valid, drain outstanding points, then cover a run in flight.
    task automatic wait_idle();
        int m;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_points.size() != 0) @(posedge i_clk);
        m = eff_log2();
        repeat (m * ((1 << m) + 6) + 64) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_WIDTH-1:0] reg_idx, int data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= reg_idx;
        i_cfg_data  <= data[CFG_DATA_WIDTH-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (reg_idx == REG_LOG2_POINTS) cfg_log2 = data & 15;
        else cfg_inv = data[0];
        @(posedge i_clk);
    endtask

    function automatic int pick_value();
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767;
            2: return ($urandom_range(1) != 0) ? 0 : -1;
            default: return int'($urandom_range(65535)) - 32768;
        endcase
    endfunction

    // One well-formed sequence: samples, twiddles, run, then reads;
    // noise (ignored twiddles, samples past n, early reads) is mixed in.
    task automatic fft_sequence(int nreads);
        int n;
        int ni;
        n = 1 << eff_log2();
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
                case ($urandom_range(2))
                    0: send_item(KIND_LOAD_TWIDDLE, $urandom_range(NPTS - 1, NPTS / 2),
                                 pick_value(), pick_value());
                    1: if (n < NPTS)
                        send_item(KIND_LOAD_SAMPLE, $urandom_range(NPTS - 1, n),
                                  pick_value(), pick_value());
                    default: begin
                        ni = $urandom_range(NPTS - 1);
                        if (read_is_safe(ni)) send_item(KIND_READ, ni, 0, 0);
                    end
                endcase
            end
            if (!pd_ok[0][i] || $urandom_range(4) != 0)
                send_item(KIND_LOAD_SAMPLE, i, pick_value(), pick_value());
        end
        for (int i = 0; i < n / 2; i++)
            if (!tw_ok[i] || $urandom_range(1) != 0)
                send_item(KIND_LOAD_TWIDDLE, i, pick_value(), pick_value());
        send_item(KIND_RUN, $urandom_range(NPTS - 1), pick_value(), pick_value());
        for (int r = 0; r < nreads; r++)
            send_item(KIND_READ, $urandom_range(NPTS - 1), pick_value(), pick_value());
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus one requested long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (stall_seen != stall_asks) begin
            stall_seen <= stall_asks;
            stall_left <= 3000;
            i_ready    <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each point taken against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : point_check
        t_point e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_points.size() == 0) begin
                orphans++;
                $display("unexpected point re=%0d im=%0d", o_out_real, o_out_imag);
            end else begin
                e = pending_points.pop_front();
                points_checked++;
                if (o_out_real !== e.re || o_out_imag !== e.im) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("point mismatch: expected (%0d,%0d) got (%0d,%0d)",
                                 e.re, e.im, o_out_real, o_out_imag);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    t_dir_row dir_rows[25];

    initial begin
        int n_err;
        int lg;
        // Directed table. Reset size is 1024; reads there touch loaded entries
        // only. Then n = 2 with a unit twiddle, conjugated -j, and size 0.
        dir_rows = '{
            '{0, KIND_LOAD_SAMPLE,     0,  32767, -32768, 0,      0,      0},
            '{0, KIND_LOAD_SAMPLE,  1023, -32768,  32767, 0,      0,      0},
            '{0, KIND_READ,            0,      0,      0, 1,  32767, -32768},
            '{0, KIND_READ,         1023,      0,      0, 1, -32768,  32767},
            '{0, KIND_LOAD_TWIDDLE,  512,      1,      1, 0,      0,      0},
            '{0, KIND_LOAD_TWIDDLE, 1023,     -1,     -1, 0,      0,      0},
            '{1, KIND_RUN, REG_LOG2_POINTS,    1,      0, 0,      0,      0},
            '{0, KIND_LOAD_TWIDDLE,    0,  32767,      0, 0,      0,      0},
            '{0, KIND_LOAD_SAMPLE,     0,    100,    200, 0,      0,      0},
            '{0, KIND_LOAD_SAMPLE,     1,     30,    -50, 0,      0,      0},
            '{0, KIND_LOAD_SAMPLE,     5,      7,      7, 0,      0,      0},
            '{0, KIND_READ,            1,      0,      0, 1,     30,    -50},
            '{0, KIND_RUN,             0,      0,      0, 0,      0,      0},
            '{0, KIND_READ,            0,      0,      0, 1,    130,    150},
            '{0, KIND_READ,            1,      0,      0, 1,     69,    249},
            '{0, KIND_READ,         1023,      0,      0, 1,     69,    249},
            '{1, KIND_RUN, REG_INVERSE,        1,      0, 0,      0,      0},
            '{0, KIND_LOAD_TWIDDLE,    0,      0, -32768, 0,      0,      0},
            '{0, KIND_RUN,             0,      0,      0, 0,      0,      0},
            '{0, KIND_READ,            0,      0,      0, 1,    130,    150},
            '{0, KIND_READ,            1,      0,      0, 1,   -250,     70},
            '{1, KIND_RUN, REG_LOG2_POINTS,    0,      0, 0,      0,      0},
            '{0, KIND_RUN,             0,      0,      0, 0,      0,      0},
            '{0, KIND_READ,            3,      0,      0, 1,   -250,     70},
            '{1, KIND_RUN, REG_INVERSE,        0,      0, 0,      0,      0}
        };

        // Hold every input at a known value through reset.
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_kind        <= KIND_LOAD_SAMPLE;
        i_index       <= '0;
        i_value_real  <= '0;
        i_value_imag  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= REG_LOG2_POINTS;
        i_cfg_data    <= '0;
        cfg_log2      = 10;
        cfg_inv       = 1'b0;
        res_in_second = 1'b0;
        stall_asks    = 0;
        send_idle_pct = 14;
        recv_idle_pct = 62;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[r]) begin
            if (dir_rows[r].is_cfg) begin
                wait_idle();
                cfg_write(dir_rows[r].idx[CFG_IDX_WIDTH-1:0], dir_rows[r].vr);
            end else begin
                send_item(dir_rows[r].kind, dir_rows[r].idx, dir_rows[r].vr,
                          dir_rows[r].vi, dir_rows[r].typed,
                          dir_rows[r].er, dir_rows[r].ei);
            end
        end

        // Random phases; the idle profile changes every four phases.
        for (int ph = 0; ph < 12; ph++) begin
            wait_idle();
            send_idle_pct = (ph < 4) ? 14 : (ph < 8) ? 62 : 0;
            recv_idle_pct = (ph < 4) ? 62 : (ph < 8) ? 14 : 0;
            if (ph == 6) begin
                // Large pass, then a repeat run in the opposite direction
                // that starts again from the first buffer.
                cfg_write(REG_LOG2_POINTS, 9);
                cfg_write(REG_INVERSE, 0);
                fft_sequence(30);
                wait_idle();
                cfg_write(REG_INVERSE, 1);
                send_item(KIND_RUN, 0, 0, 0);
                for (int r = 0; r < 30; r++)
                    send_item(KIND_READ, $urandom_range(NPTS - 1), 0, 0);
            end else begin
                lg = $urandom_range(6);
                cfg_write(REG_LOG2_POINTS, lg);
                cfg_write(REG_INVERSE, $urandom_range(1));
                // Hold the receiver off while reads keep coming in.
                if (ph == 2) stall_asks++;
                fft_sequence((lg < 5) ? (2 << lg) + 4 : 24);
            end
        end

        wait_idle();
        n_err = mismatches + orphans + pending_points.size();
        $display("Covered %0d transactions: %0d runs, %0d reads, %0d points checked.",
                 items_sent, runs_done, reads_sent, points_checked);
        $display("Sizes 2..64 and 512, size 0 clamped, repeat runs, both directions, %0d errors.",
                 n_err);
        if (n_err == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
